// ===== src/lpbpm_pkg.sv =====
// ----------------------------------------------------------------------------
// lpbpm_pkg
// Shared types and constants of the buffer pool frame table.
// ----------------------------------------------------------------------------
package lpbpm_pkg;

  // field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned FILE_W = 10;
  localparam int unsigned PAGE_W = 31;
  localparam int unsigned PIN_W  = 16;
  localparam int unsigned LINK_W = 6;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned SLOT_W = 5;

  // link value that ends a list
  localparam logic [LINK_W-1:0] NIL = 6'h3F;

  // operation codes
  localparam logic [OP_W-1:0] OP_GET   = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
  localparam logic [OP_W-1:0] OP_DIRTY = 3'd2;
  localparam logic [OP_W-1:0] OP_UNPIN = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;
  localparam logic [OP_W-1:0] OP_FORCE = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd6;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_PINNED     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_IN_BUF = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNPINNED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_FREE    = 3'd4;

  // one frame descriptor as held in memory
  typedef struct packed {
    logic [FILE_W-1:0] file;
    logic [PAGE_W-1:0] page;
    logic              dirty;
    logic [PIN_W-1:0]  pins;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] next;
  } row_t;

  typedef enum logic [1:0] {
    PIN_KEEP = 2'd0,
    PIN_INC  = 2'd1,
    PIN_DEC  = 2'd2,
    PIN_ONE  = 2'd3
  } pin_op_e;

  // change applied to a descriptor on its write back
  typedef struct packed {
    logic              set_prev;
    logic [LINK_W-1:0] prev;
    logic              set_next;
    logic [LINK_W-1:0] next;
    logic              set_dirty;
    logic              dirty;
    pin_op_e           pin_op;
    logic              set_tag;
  } row_edit_t;

  // result register
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [FILE_W-1:0] cmd_file;
    logic [PAGE_W-1:0] cmd_page;
    logic              last;
  } rsp_t;

endpackage

// ===== src/lpbpm_if.sv =====
// ----------------------------------------------------------------------------
// lpbpm_if
// Request and response channels of the buffer pool frame table.
// ----------------------------------------------------------------------------
interface lpbpm_req_if
  import lpbpm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [FILE_W-1:0] file_id;
  logic [PAGE_W-1:0] page_number;
  logic              allow_multiple_pins;
  logic              force_all;

  modport source (
    output valid, opcode, file_id, page_number, allow_multiple_pins, force_all,
    input  ready
  );
  modport sink (
    input  valid, opcode, file_id, page_number, allow_multiple_pins, force_all,
    output ready
  );
endinterface

interface lpbpm_rsp_if
  import lpbpm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot_index;
  logic [FILE_W-1:0] cmd_file;
  logic [PAGE_W-1:0] cmd_page;
  logic              last;

  modport source (
    output valid, kind, status, slot_index, cmd_file, cmd_page, last,
    input  ready
  );
  modport sink (
    input  valid, kind, status, slot_index, cmd_file, cmd_page, last,
    output ready
  );
endinterface

// ===== src/lpbpm_ram.sv =====
// ----------------------------------------------------------------------------
// lpbpm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lpbpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/lru_pinned_buffer_pool_manager.sv =====
// ----------------------------------------------------------------------------
// lru_pinned_buffer_pool_manager
// Frame table of a page buffer pool: lookup, LRU victim choice, pin counts,
// flush and force walks, all held in one descriptor RAM.
// ----------------------------------------------------------------------------
// Lookup reads one descriptor a cycle, over NUM_SLOTS descriptors at most;
// each descriptor change is a read-modify-write through S_MEM, and a list
// move is an unlink and a relink built of such changes. Throughput: one
// transaction at a time, plus output stalls; the victim search of get_page
// may walk the whole LRU list, and flush/force/clear walk it frame by frame.
// Reset: asynchronous; in-use and written marks clear at once.
module lru_pinned_buffer_pool_manager
  import lpbpm_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpbpm_req_if.sink   req_i,
  lpbpm_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [21:0] {
    S_IDLE  = 22'd1 << 0,
    S_FIND  = 22'd1 << 1,
    S_MEM   = 22'd1 << 2,
    S_HIT   = 22'd1 << 3,
    S_MISS  = 22'd1 << 4,
    S_UL    = 22'd1 << 5,
    S_UL_A  = 22'd1 << 6,
    S_UL_B  = 22'd1 << 7,
    S_LH    = 22'd1 << 8,
    S_LH_A  = 22'd1 << 9,
    S_ALLOC = 22'd1 << 10,
    S_AF    = 22'd1 << 11,
    S_VSRCH = 22'd1 << 12,
    S_VCHK  = 22'd1 << 13,
    S_VREL  = 22'd1 << 14,
    S_AINIT = 22'd1 << 15,
    S_WALK  = 22'd1 << 16,
    S_WCHK  = 22'd1 << 17,
    S_WNEXT = 22'd1 << 18,
    S_REL   = 22'd1 << 19,
    S_RELB  = 22'd1 << 20,
    S_FINAL = 22'd1 << 21
  } state_e;

  // helpers
  function automatic logic ok_link(logic [LINK_W-1:0] x);
    return x < LINK_W'(NUM_SLOTS);
  endfunction

  function automatic row_t reset_row(logic [AW-1:0] idx);
    row_t r;
    r       = '0;
    r.prev  = (idx == '0) ? NIL : LINK_W'(idx) - 1'b1;
    r.next  = (idx == AW'(NUM_SLOTS - 1)) ? NIL : LINK_W'(idx) + 1'b1;
    return r;
  endfunction

  function automatic row_edit_t ed_links(logic [LINK_W-1:0] p, logic [LINK_W-1:0] n);
    row_edit_t e;
    e          = '0;
    e.set_prev = 1'b1;
    e.prev     = p;
    e.set_next = 1'b1;
    e.next     = n;
    return e;
  endfunction

  function automatic row_edit_t ed_prev(logic [LINK_W-1:0] p);
    row_edit_t e;
    e          = '0;
    e.set_prev = 1'b1;
    e.prev     = p;
    return e;
  endfunction

  function automatic row_edit_t ed_next(logic [LINK_W-1:0] n);
    row_edit_t e;
    e          = '0;
    e.set_next = 1'b1;
    e.next     = n;
    return e;
  endfunction

  function automatic row_edit_t ed_dirty(logic d);
    row_edit_t e;
    e           = '0;
    e.set_dirty = 1'b1;
    e.dirty     = d;
    return e;
  endfunction

  function automatic row_edit_t ed_pins(pin_op_e op);
    row_edit_t e;
    e        = '0;
    e.pin_op = op;
    return e;
  endfunction

  function automatic row_edit_t ed_init();
    row_edit_t e;
    e           = '0;
    e.set_dirty = 1'b1;
    e.pin_op    = PIN_ONE;
    e.set_tag   = 1'b1;
    return e;
  endfunction

  function automatic rsp_t mk_rsp(logic [KIND_W-1:0] kind, logic [STAT_W-1:0] st,
                                  logic [LINK_W-1:0] slot, logic [FILE_W-1:0] f,
                                  logic [PAGE_W-1:0] p, logic last);
    rsp_t r;
    r.kind       = kind;
    r.status     = st;
    r.slot_index = slot[SLOT_W-1:0];
    r.cmd_file   = f;
    r.cmd_page   = p;
    r.last       = last;
    return r;
  endfunction

  // registers
  state_e                 state_q, state_d, ret_q, ret_d;
  state_e                 uret_q, uret_d, lret_q, lret_d;
  logic [AW-1:0]          a_q, a_d;
  row_edit_t              edit_q, edit_d;
  row_t                   rowbuf_q, rowbuf_d;
  logic [LINK_W-1:0]      s_q, s_d, nx_q, nx_d, up_q, up_d, uq_q, uq_d;
  logic [LINK_W-1:0]      head_q, head_d, tail_q, tail_d, free_q, free_d;
  logic [LINK_W-1:0]      sl_q, sl_d;
  logic [STAT_W-1:0]      st_q, st_d;
  logic [CW-1:0]          k_q, k_d;
  logic [NUM_SLOTS-1:0]   in_use_q, in_use_d, touched_q, touched_d;
  logic [OP_W-1:0]        op_q, op_d;
  logic [FILE_W-1:0]      file_q, file_d;
  logic [PAGE_W-1:0]      page_q, page_d;
  logic                   multi_q, multi_d, all_q, all_d;
  logic                   out_vld_q, out_vld_d;
  rsp_t                   out_q, out_d;

  // memory signals
  logic                   ram_we;
  row_t                   ram_wdata, ram_rdata, rd_row, wr_row;
  logic                   out_free;
  logic                   edit_any;

  lpbpm_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (a_q),
    .wdata_i (ram_wdata),
    .raddr_i (a_d),
    .rdata_o (ram_rdata)
  );

  // descriptor as seen: never written entries read as their reset value
  assign rd_row = touched_q[a_q] ? ram_rdata : reset_row(a_q);

  // apply the pending edit
  always_comb begin
    wr_row = rd_row;
    if (edit_q.set_prev) wr_row.prev = edit_q.prev;
    if (edit_q.set_next) wr_row.next = edit_q.next;
    if (edit_q.set_dirty) wr_row.dirty = edit_q.dirty;
    if (edit_q.set_tag) begin
      wr_row.file = file_q;
      wr_row.page = page_q;
    end
    case (edit_q.pin_op)
      PIN_INC: if (rd_row.pins != '1) wr_row.pins = rd_row.pins + 1'b1;
      PIN_DEC: wr_row.pins = rd_row.pins - 1'b1;
      PIN_ONE: wr_row.pins = PIN_W'(1);
      default: wr_row.pins = rd_row.pins;
    endcase
  end

  assign edit_any = edit_q.set_prev | edit_q.set_next | edit_q.set_dirty |
                    edit_q.set_tag | (edit_q.pin_op != PIN_KEEP);
  assign out_free = !out_vld_q || rsp_o.ready;

  // handshake and payload
  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.kind       = out_q.kind;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.slot_index = out_q.slot_index;
  assign rsp_o.cmd_file   = out_q.cmd_file;
  assign rsp_o.cmd_page   = out_q.cmd_page;
  assign rsp_o.last       = out_q.last;

  // sequencer
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    uret_d    = uret_q;
    lret_d    = lret_q;
    a_d       = a_q;
    edit_d    = edit_q;
    rowbuf_d  = rowbuf_q;
    s_d       = s_q;
    nx_d      = nx_q;
    up_d      = up_q;
    uq_d      = uq_q;
    head_d    = head_q;
    tail_d    = tail_q;
    free_d    = free_q;
    sl_d      = sl_q;
    st_d      = st_q;
    k_d       = k_q;
    in_use_d  = in_use_q;
    touched_d = touched_q;
    op_d      = op_q;
    file_d    = file_q;
    page_d    = page_q;
    multi_d   = multi_q;
    all_d     = all_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    ram_we    = 1'b0;
    ram_wdata = wr_row;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d    = req_i.opcode;
          file_d  = req_i.file_id;
          page_d  = req_i.page_number;
          multi_d = req_i.allow_multiple_pins;
          all_d   = req_i.force_all;
          st_d    = ST_OK;
          sl_d    = '0;
          case (req_i.opcode)
            OP_GET, OP_ALLOC, OP_DIRTY, OP_UNPIN: begin
              a_d     = '0;
              state_d = S_FIND;
            end
            OP_FLUSH, OP_FORCE, OP_CLEAR: begin
              s_d     = head_q;
              k_d     = '0;
              state_d = S_WALK;
            end
            default: state_d = S_FINAL;
          endcase
        end
      end

      // associative lookup, one descriptor a cycle
      S_FIND: begin
        if (in_use_q[a_q] && rd_row.file == file_q && rd_row.page == page_q) begin
          s_d      = LINK_W'(a_q);
          rowbuf_d = rd_row;
          state_d  = S_HIT;
        end else if (a_q == AW'(NUM_SLOTS - 1)) begin
          state_d = S_MISS;
        end else begin
          a_d = a_q + 1'b1;
        end
      end

      // read-modify-write of one descriptor
      S_MEM: begin
        rowbuf_d = rd_row;
        if (edit_any) begin
          ram_we            = 1'b1;
          touched_d[a_q]    = 1'b1;
        end
        state_d = ret_q;
      end

      S_HIT: begin
        sl_d   = s_q;
        uret_d = S_LH;
        lret_d = S_FINAL;
        a_d    = s_q[AW-1:0];
        case (op_q)
          OP_GET: begin
            if (!multi_q && rowbuf_q.pins != '0) begin
              st_d    = ST_PINNED;
              state_d = S_FINAL;
            end else begin
              edit_d  = ed_pins(PIN_INC);
              ret_d   = S_UL;
              state_d = S_MEM;
            end
          end
          OP_DIRTY: begin
            if (rowbuf_q.pins == '0) begin
              st_d    = ST_UNPINNED;
              state_d = S_FINAL;
            end else begin
              edit_d  = ed_dirty(1'b1);
              ret_d   = S_UL;
              state_d = S_MEM;
            end
          end
          OP_UNPIN: begin
            if (rowbuf_q.pins == '0) begin
              st_d    = ST_UNPINNED;
              state_d = S_FINAL;
            end else begin
              edit_d  = ed_pins(PIN_DEC);
              ret_d   = (rowbuf_q.pins == PIN_W'(1)) ? S_UL : S_FINAL;
              state_d = S_MEM;
            end
          end
          default: state_d = S_FINAL;
        endcase
      end

      S_MISS: begin
        if (op_q == OP_GET || op_q == OP_ALLOC) begin
          state_d = S_ALLOC;
        end else begin
          st_d    = ST_NOT_IN_BUF;
          state_d = S_FINAL;
        end
      end

      // unlink: clear own links, then patch neighbours
      S_UL: begin
        a_d     = s_q[AW-1:0];
        edit_d  = ed_links(NIL, NIL);
        ret_d   = S_UL_A;
        state_d = S_MEM;
      end

      S_UL_A: begin
        up_d = rowbuf_q.prev;
        uq_d = rowbuf_q.next;
        if (head_q == s_q) head_d = rowbuf_q.next;
        if (tail_q == s_q) tail_d = rowbuf_q.prev;
        if (ok_link(rowbuf_q.next)) begin
          a_d     = rowbuf_q.next[AW-1:0];
          edit_d  = ed_prev(rowbuf_q.prev);
          ret_d   = S_UL_B;
          state_d = S_MEM;
        end else begin
          state_d = S_UL_B;
        end
      end

      S_UL_B: begin
        if (ok_link(up_q)) begin
          a_d     = up_q[AW-1:0];
          edit_d  = ed_next(uq_q);
          ret_d   = uret_q;
          state_d = S_MEM;
        end else begin
          state_d = uret_q;
        end
      end

      // link at the most recent end
      S_LH: begin
        a_d     = s_q[AW-1:0];
        edit_d  = ed_links(NIL, head_q);
        ret_d   = S_LH_A;
        state_d = S_MEM;
      end

      S_LH_A: begin
        head_d = s_q;
        if (!ok_link(tail_q)) tail_d = s_q;
        if (ok_link(head_q)) begin
          a_d     = head_q[AW-1:0];
          edit_d  = ed_prev(s_q);
          ret_d   = lret_q;
          state_d = S_MEM;
        end else begin
          state_d = lret_q;
        end
      end

      // frame allocation: free list first, else LRU victim
      S_ALLOC: begin
        if (ok_link(free_q)) begin
          s_d     = free_q;
          a_d     = free_q[AW-1:0];
          edit_d  = '0;
          ret_d   = S_AF;
          state_d = S_MEM;
        end else begin
          s_d     = tail_q;
          k_d     = '0;
          state_d = S_VSRCH;
        end
      end

      S_AF: begin
        free_d  = rowbuf_q.next;
        lret_d  = S_AINIT;
        state_d = S_LH;
      end

      S_VSRCH: begin
        if (ok_link(s_q) && k_q < CW'(NUM_SLOTS)) begin
          a_d     = s_q[AW-1:0];
          edit_d  = '0;
          ret_d   = S_VCHK;
          state_d = S_MEM;
        end else begin
          st_d    = ST_NO_FREE;
          state_d = S_FINAL;
        end
      end

      S_VCHK: begin
        if (rowbuf_q.pins == '0) begin
          if (rowbuf_q.dirty) begin
            if (out_free) begin
              out_vld_d = 1'b1;
              out_d     = mk_rsp(KIND_WRITE, ST_OK, s_q, rowbuf_q.file,
                                 rowbuf_q.page, 1'b0);
              a_d       = s_q[AW-1:0];
              edit_d    = ed_dirty(1'b0);
              ret_d     = S_VREL;
              state_d   = S_MEM;
            end
          end else begin
            state_d = S_VREL;
          end
        end else begin
          s_d     = rowbuf_q.prev;
          k_d     = k_q + 1'b1;
          state_d = S_VSRCH;
        end
      end

      S_VREL: begin
        in_use_d[s_q[AW-1:0]] = 1'b0;
        uret_d  = S_LH;
        lret_d  = S_AINIT;
        state_d = S_UL;
      end

      // new descriptor, read command on get_page
      S_AINIT: begin
        if (op_q != OP_GET || out_free) begin
          if (op_q == OP_GET) begin
            out_vld_d = 1'b1;
            out_d     = mk_rsp(KIND_READ, ST_OK, s_q, file_q, page_q, 1'b0);
          end
          in_use_d[s_q[AW-1:0]] = 1'b1;
          sl_d    = s_q;
          a_d     = s_q[AW-1:0];
          edit_d  = ed_init();
          ret_d   = S_FINAL;
          state_d = S_MEM;
        end
      end

      // walk of the LRU list from the head
      S_WALK: begin
        if (ok_link(s_q) && k_q < CW'(NUM_SLOTS)) begin
          a_d     = s_q[AW-1:0];
          edit_d  = '0;
          ret_d   = S_WCHK;
          state_d = S_MEM;
        end else begin
          state_d = S_FINAL;
        end
      end

      S_WCHK: begin
        nx_d    = rowbuf_q.next;
        state_d = S_WNEXT;
        a_d     = s_q[AW-1:0];
        case (op_q)
          OP_CLEAR: begin
            if (rowbuf_q.pins == '0) state_d = S_REL;
          end
          OP_FLUSH: begin
            if (rowbuf_q.file == file_q) begin
              if (rowbuf_q.pins != '0) begin
                st_d = ST_PINNED;
              end else if (rowbuf_q.dirty) begin
                state_d = S_WCHK;
                if (out_free) begin
                  out_vld_d = 1'b1;
                  out_d     = mk_rsp(KIND_WRITE, ST_OK, s_q, file_q, rowbuf_q.page, 1'b0);
                  edit_d    = ed_dirty(1'b0);
                  ret_d     = S_REL;
                  state_d   = S_MEM;
                end
              end else begin
                state_d = S_REL;
              end
            end
          end
          OP_FORCE: begin
            if (rowbuf_q.file == file_q && (all_q || rowbuf_q.page == page_q) &&
                rowbuf_q.dirty) begin
              state_d = S_WCHK;
              if (out_free) begin
                out_vld_d = 1'b1;
                out_d     = mk_rsp(KIND_WRITE, ST_OK, s_q, file_q, rowbuf_q.page, 1'b0);
                edit_d    = ed_dirty(1'b0);
                ret_d     = S_WNEXT;
                state_d   = S_MEM;
              end
            end
          end
          default: state_d = S_WNEXT;
        endcase
      end

      S_WNEXT: begin
        s_d     = nx_q;
        k_d     = k_q + 1'b1;
        state_d = S_WALK;
      end

      // release to the free list
      S_REL: begin
        in_use_d[s_q[AW-1:0]] = 1'b0;
        uret_d  = S_RELB;
        state_d = S_UL;
      end

      S_RELB: begin
        free_d  = s_q;
        a_d     = s_q[AW-1:0];
        edit_d  = ed_next(free_q);
        ret_d   = S_WNEXT;
        state_d = S_MEM;
      end

      S_FINAL: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = mk_rsp(KIND_STATUS, st_q, sl_q, '0, '0, 1'b1);
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      uret_q    <= S_IDLE;
      lret_q    <= S_IDLE;
      head_q    <= NIL;
      tail_q    <= NIL;
      free_q    <= '0;
      in_use_q  <= '0;
      touched_q <= '0;
      out_vld_q <= 1'b0;
      edit_q    <= '0;
      a_q       <= '0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      uret_q    <= uret_d;
      lret_q    <= lret_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      free_q    <= free_d;
      in_use_q  <= in_use_d;
      touched_q <= touched_d;
      out_vld_q <= out_vld_d;
      edit_q    <= edit_d;
      a_q       <= a_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    rowbuf_q <= rowbuf_d;
    s_q      <= s_d;
    nx_q     <= nx_d;
    up_q     <= up_d;
    uq_q     <= uq_d;
    sl_q     <= sl_d;
    st_q     <= st_d;
    k_q      <= k_d;
    op_q     <= op_d;
    file_q   <= file_d;
    page_q   <= page_d;
    multi_q  <= multi_d;
    all_q    <= all_d;
    out_q    <= out_d;
  end

  // memory accesses stay inside the frame range
  a_mem_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MEM) |-> (32'(a_q) < NUM_SLOTS))
    else $error("descriptor access outside the frame range");

  // the LRU list is empty at both ends or at neither
  a_list_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((head_q == NIL) == (tail_q == NIL)))
    else $error("LRU head and tail disagree");

  // the final status ends the transaction
  a_final_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL && out_free) |=> (state_q == S_IDLE && out_vld_q && out_q.last))
    else $error("final status not issued");

  // no new request taken while a write back is pending in the walk
  a_walk_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WCHK && !out_free) |=> (state_q == S_WCHK || state_q == S_WNEXT ||
                                         state_q == S_REL))
    else $error("walk left a frame with its write back pending");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the buffer pool frame table against a frame table model kept here.
// Directed transactions cover hits, misses, pins, dirty pages, flush, force,
// clear and the unused opcode. Random phases with sender idling and receiver
// stalls then exercise replacement, write-back and running out of free frames.
// ----------------------------------------------------------------------------
module testbench;
  import lpbpm_pkg::*;

  localparam int FRAMES = 32;
  localparam int NO_LINK = int'(NIL);
  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lpbpm_req_if req_if ();
  lpbpm_rsp_if rsp_if ();

  lru_pinned_buffer_pool_manager #(.NUM_SLOTS(FRAMES)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // model of the frame table
  logic [FILE_W-1:0] pool_file  [FRAMES];
  logic [PAGE_W-1:0] pool_page  [FRAMES];
  bit                pool_used  [FRAMES];
  bit                pool_dirty [FRAMES];
  int unsigned       pool_pins  [FRAMES];
  int                pool_prev  [FRAMES];
  int                pool_next  [FRAMES];
  int                mru_frame;
  int                lru_frame;
  int                free_frame;

  rsp_t expected_rsp_q [$];
  int   errors = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;

  function automatic bit valid_link(int s);
    return s >= 0 && s < FRAMES;
  endfunction

  function automatic void push_rsp(logic [KIND_W-1:0] k, logic [STAT_W-1:0] st, int s,
                                   logic [FILE_W-1:0] f, logic [PAGE_W-1:0] p, bit l);
    rsp_t r;
    r.kind = k;
    r.status = st;
    r.slot_index = s[SLOT_W-1:0];
    r.cmd_file = f;
    r.cmd_page = p;
    r.last = l;
    expected_rsp_q.push_back(r);
  endfunction

  function automatic void unlink_frame(int s);
    int p;
    int q;
    p = pool_prev[s];
    q = pool_next[s];
    if (mru_frame == s) mru_frame = q;
    if (lru_frame == s) lru_frame = p;
    if (valid_link(q)) pool_prev[q] = p;
    if (valid_link(p)) pool_next[p] = q;
    pool_prev[s] = NO_LINK;
    pool_next[s] = NO_LINK;
  endfunction

  function automatic void link_mru(int s);
    pool_next[s] = mru_frame;
    pool_prev[s] = NO_LINK;
    if (valid_link(mru_frame)) pool_prev[mru_frame] = s;
    mru_frame = s;
    if (!valid_link(lru_frame)) lru_frame = s;
  endfunction

  function automatic void move_to_mru(int s);
    unlink_frame(s);
    link_mru(s);
  endfunction

  function automatic void free_up(int s);
    pool_used[s] = 1'b0;
    unlink_frame(s);
    pool_next[s] = free_frame;
    free_frame = s;
  endfunction

  function automatic int lookup(logic [FILE_W-1:0] f, logic [PAGE_W-1:0] p);
    for (int i = 0; i < FRAMES; i++)
      if (pool_used[i] && pool_file[i] == f && pool_page[i] == p) return i;
    return NO_LINK;
  endfunction

  // free list first, else least recent unpinned frame with write-back if dirty
  function automatic int take_frame();
    int s;
    if (valid_link(free_frame)) begin
      s = free_frame;
      free_frame = pool_next[s];
      link_mru(s);
      return s;
    end
    s = lru_frame;
    for (int k = 0; valid_link(s) && k < FRAMES; k++) begin
      if (pool_pins[s] == 0) break;
      s = pool_prev[s];
    end
    if (!valid_link(s) || pool_pins[s] != 0) return NO_LINK;
    if (pool_dirty[s]) begin
      push_rsp(KIND_WRITE, ST_OK, s, pool_file[s], pool_page[s], 1'b0);
      pool_dirty[s] = 1'b0;
    end
    pool_used[s] = 1'b0;
    move_to_mru(s);
    return s;
  endfunction

  function automatic void reset_pool();
    for (int i = 0; i < FRAMES; i++) begin
      pool_file[i] = '0;
      pool_page[i] = '0;
      pool_used[i] = 1'b0;
      pool_dirty[i] = 1'b0;
      pool_pins[i] = 0;
      pool_prev[i] = (i == 0) ? NO_LINK : i - 1;
      pool_next[i] = (i == FRAMES - 1) ? NO_LINK : i + 1;
    end
    mru_frame = NO_LINK;
    lru_frame = NO_LINK;
    free_frame = 0;
  endfunction

  // works out every result of one accepted transaction
  function automatic void predict_transaction(logic [OP_W-1:0] op, logic [FILE_W-1:0] f,
                                              logic [PAGE_W-1:0] p, bit multi, bit all);
    int s;
    int nx;
    logic [STAT_W-1:0] st;
    int sl;
    st = ST_OK;
    sl = 0;
    case (op)
      OP_GET, OP_ALLOC: begin
        s = lookup(f, p);
        if (valid_link(s)) begin
          sl = s;
          if (op == OP_GET) begin
            if (!multi && pool_pins[s] > 0) st = ST_PINNED;
            else begin
              if (pool_pins[s] < 16'hFFFF) pool_pins[s]++;
              move_to_mru(s);
            end
          end
        end else begin
          s = take_frame();
          if (!valid_link(s)) st = ST_NO_FREE;
          else begin
            if (op == OP_GET) push_rsp(KIND_READ, ST_OK, s, f, p, 1'b0);
            pool_file[s] = f;
            pool_page[s] = p;
            pool_used[s] = 1'b1;
            pool_dirty[s] = 1'b0;
            pool_pins[s] = 1;
            sl = s;
          end
        end
      end
      OP_DIRTY, OP_UNPIN: begin
        s = lookup(f, p);
        if (!valid_link(s)) st = ST_NOT_IN_BUF;
        else begin
          sl = s;
          if (pool_pins[s] == 0) st = ST_UNPINNED;
          else if (op == OP_DIRTY) begin
            pool_dirty[s] = 1'b1;
            move_to_mru(s);
          end else begin
            pool_pins[s]--;
            if (pool_pins[s] == 0) move_to_mru(s);
          end
        end
      end
      OP_FLUSH, OP_FORCE, OP_CLEAR: begin
        s = mru_frame;
        for (int k = 0; valid_link(s) && k < FRAMES; k++) begin
          nx = pool_next[s];
          if (op == OP_CLEAR) begin
            if (pool_pins[s] == 0) free_up(s);
          end else if (pool_file[s] == f) begin
            if (op == OP_FLUSH) begin
              if (pool_pins[s] != 0) st = ST_PINNED;
              else begin
                if (pool_dirty[s]) begin
                  push_rsp(KIND_WRITE, ST_OK, s, f, pool_page[s], 1'b0);
                  pool_dirty[s] = 1'b0;
                end
                free_up(s);
              end
            end else if ((all || pool_page[s] == p) && pool_dirty[s]) begin
              push_rsp(KIND_WRITE, ST_OK, s, f, pool_page[s], 1'b0);
              pool_dirty[s] = 1'b0;
            end
          end
          s = nx;
        end
      end
      default: ;
    endcase
    push_rsp(KIND_STATUS, st, sl, '0, '0, 1'b1);
  endfunction

  // drives one request and waits for its handshake
  task automatic send_req(logic [OP_W-1:0] op, logic [FILE_W-1:0] f, logic [PAGE_W-1:0] p,
                          bit multi = 1'b0, bit all = 1'b0);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.opcode <= op;
    req_if.file_id <= f;
    req_if.page_number <= p;
    req_if.allow_multiple_pins <= multi;
    req_if.force_all <= all;
    do @(posedge clk_i); while (!req_if.ready);
    predict_transaction(op, f, p, multi, all);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // checks each response transaction and drives ready
  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.kind = rsp_if.kind;
      got.status = rsp_if.status;
      got.slot_index = rsp_if.slot_index;
      got.cmd_file = rsp_if.cmd_file;
      got.cmd_page = rsp_if.cmd_page;
      got.last = rsp_if.last;
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected response, actual %p", $realtime, got);
        errors++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (got.kind !== want.kind || got.status !== want.status ||
            got.slot_index !== want.slot_index || got.cmd_file !== want.cmd_file ||
            got.cmd_page !== want.cmd_page || got.last !== want.last) begin
          $display("%0t: mismatch, expected %p, actual %p", $realtime, want, got);
          errors++;
        end
      end
    end
    rsp_if.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // hits, misses, pin rules and the status codes
  task automatic test_pins_and_status();
    send_req(OP_GET, 10'd0, 31'd0);
    send_req(OP_GET, 10'd0, 31'd0);
    send_req(OP_GET, 10'd0, 31'd0, 1'b1);
    send_req(OP_ALLOC, 10'd0, 31'd0);
    send_req(OP_ALLOC, 10'h3FF, 31'h7FFF_FFFF, 1'b1);
    send_req(OP_DIRTY, 10'h3FF, 31'h7FFF_FFFF);
    send_req(OP_DIRTY, 10'h155, 31'h2AAA_AAAA);
    send_req(OP_UNPIN, 10'h2AA, 31'h5555_5555);
    send_req(OP_UNPIN, 10'd0, 31'd0);
    send_req(OP_UNPIN, 10'd0, 31'd0);
    send_req(OP_UNPIN, 10'd0, 31'd0);
    send_req(OP_DIRTY, 10'd0, 31'd0);
    send_req(OP_GET, 10'd0, 31'd1);
    send_req(OP_DIRTY, 10'd0, 31'd1);
  endtask

  // force, flush, clear and the unused opcode
  task automatic test_walks();
    send_req(OP_FORCE, 10'h3FF, 31'h7FFF_FFFF);
    send_req(OP_DIRTY, 10'h3FF, 31'h7FFF_FFFF);
    send_req(OP_FORCE, 10'h3FF, 31'd0, 1'b0, 1'b1);
    send_req(OP_FLUSH, 10'h3FF, 31'd0);
    send_req(OP_UNPIN, 10'd0, 31'd1);
    send_req(OP_FLUSH, 10'd0, 31'd0);
    send_req(OP_UNPIN, 10'h3FF, 31'h7FFF_FFFF);
    send_req(OP_CLEAR, 10'd0, 31'd0);
    send_req(OP_SPARE, 10'h3FF, 31'h7FFF_FFFF, 1'b1, 1'b1);
    drain();
  endtask

  // random traffic over a small set of pages so that hits and evictions occur
  task automatic test_random(int count, int idle, int stall);
    logic [OP_W-1:0]   op;
    logic [FILE_W-1:0] f;
    logic [PAGE_W-1:0] p;
    int w;
    idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      w = $urandom_range(99);
      if (w < 32) op = OP_GET;
      else if (w < 40) op = OP_ALLOC;
      else if (w < 54) op = OP_DIRTY;
      else if (w < 82) op = OP_UNPIN;
      else if (w < 88) op = OP_FLUSH;
      else if (w < 95) op = OP_FORCE;
      else if (w < 98) op = OP_CLEAR;
      else op = OP_W'($urandom_range(7));
      f = ($urandom_range(19) == 0) ? 10'($urandom) : 10'($urandom_range(2) * 511);
      if ($urandom_range(19) == 0) p = 31'($urandom);
      else if ($urandom_range(9) == 0) p = 31'h7FFF_FFFF;
      else p = 31'($urandom_range(13));
      send_req(op, f, p, 1'($urandom), 1'($urandom));
    end
    drain();
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.opcode = OP_GET;
    req_if.file_id = '0;
    req_if.page_number = '0;
    req_if.allow_multiple_pins = 1'b0;
    req_if.force_all = 1'b0;
    rsp_if.ready = 1'b0;
    reset_pool();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pins_and_status();
    test_walks();
    test_random(80, 0, 0);
    test_random(80, 81, 0);
    test_random(80, 0, 81);
    test_random(80, 20, 20);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_rsp_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
src/lpbpm_pkg.sv
src/lpbpm_if.sv
src/lpbpm_ram.sv
src/lru_pinned_buffer_pool_manager.sv
dv/testbench.sv
